// ===== rtl/hrv_pkg.sv =====
// ----------------------------------------------------------------------------
// HTTP request head validator package
// Shared constants, match tables and result codes for the validator.
// ----------------------------------------------------------------------------
package hrv_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned TOKEN_LEN    = 8;
    localparam int unsigned TERM_LEN     = 4;
    localparam int unsigned METHOD_COUNT = 7;
    localparam int unsigned METHOD_MAX   = 8;

    localparam logic [BYTE_W-1:0] MIN_LEN_RESET = 8'd10;
    localparam logic [BYTE_W-1:0] COUNT_MAX     = 8'd255;

    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [2:0]        token_pos_t;
    typedef logic [1:0]        term_pos_t;
    typedef logic [METHOD_COUNT-1:0] method_mask_t;
    typedef logic [3:0]        method_len_t;

    // " HTTP/1."
    localparam byte_t TOKEN_TEXT [TOKEN_LEN] = '{
        8'h20, 8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E
    };

    // CR LF CR LF
    localparam byte_t TERM_TEXT [TERM_LEN] = '{8'h0D, 8'h0A, 8'h0D, 8'h0A};

    // Method prefixes including the trailing space, zero padded
    localparam byte_t METHOD_TEXT [METHOD_COUNT][METHOD_MAX] = '{
        '{8'h47, 8'h45, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00}, // GET
        '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00}, // POST
        '{8'h50, 8'h55, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00}, // PUT
        '{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45, 8'h20, 8'h00}, // DELETE
        '{8'h48, 8'h45, 8'h41, 8'h44, 8'h20, 8'h00, 8'h00, 8'h00}, // HEAD
        '{8'h4F, 8'h50, 8'h54, 8'h49, 8'h4F, 8'h4E, 8'h53, 8'h20}, // OPTIONS
        '{8'h50, 8'h41, 8'h54, 8'h43, 8'h48, 8'h20, 8'h00, 8'h00}  // PATCH
    };

    localparam method_len_t METHOD_LEN [METHOD_COUNT] = '{
        4'd4, 4'd5, 4'd4, 4'd7, 4'd5, 4'd8, 4'd6
    };

    // Result codes, in check priority order
    typedef enum logic [2:0] {
        REASON_OK         = 3'd0,
        REASON_SHORT      = 3'd1,
        REASON_NO_TOKEN   = 3'd2,
        REASON_NO_TERM    = 3'd3,
        REASON_BARE_LF    = 3'd4,
        REASON_BAD_METHOD = 3'd5
    } reason_t;

endpackage

// ===== rtl/http_request_head_validator.sv =====
// ----------------------------------------------------------------------------
// HTTP request head validator
// Byte-streaming checker for an HTTP/1 request head with one verdict a request.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request byte per item (s_data_byte) and s_end_of_request
//   on the final byte. A zero byte ends the string; later bytes up to the
//   final one are ignored.
//   m_ channel: one item per request, issued for the final byte, carrying
//   m_accepted and m_reject_reason (first failing check).
//   cfg channel: writes min_request_length; write only while idle.
// Timing: an item enters an input register and is then folded into the matcher
//   state; for a final byte the verdict lands in the output register at that
//   same edge. One byte is taken every cycle; the only limit is the single
//   output register.
// Stall: while a verdict waits on m_ready, non-final bytes keep flowing; a
//   final byte waits in the input register until the output frees up.
// Reset: aresetn (synchronous, low) clears all matchers, empties both
//   registers and loads min_request_length with 10.
// ----------------------------------------------------------------------------
module http_request_head_validator
    import hrv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_min_request_length,
    // request bytes
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_request,
    // verdicts
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accepted,
    output logic [2:0]  m_reject_reason
);

    // configuration register
    byte_t        min_len_reg;

    // input register
    logic         in_valid_reg;
    byte_t        in_byte_reg;
    logic         in_last_reg;

    // matcher state
    byte_t        count_reg,      count_next;
    token_pos_t   token_pos_reg,  token_pos_next;
    logic         token_seen_reg, token_seen_next;
    term_pos_t    term_pos_reg,   term_pos_next;
    logic         head_end_reg,   head_end_next;
    logic         bare_lf_reg,    bare_lf_next;
    logic         prev_cr_reg,    prev_cr_next;
    method_mask_t method_reg,     method_next;
    logic         ended_reg,      ended_next;

    // output register
    logic         out_valid_reg;
    logic         out_accepted_reg;
    reason_t      out_reason_reg;
    reason_t      reason;
    logic         method_ok;
    logic         take_byte;
    logic         advance;

    // an item leaves the input register unless it is final and the output holds a verdict not yet taken
    assign advance   = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_valid         = out_valid_reg;
    assign m_accepted      = out_accepted_reg;
    assign m_reject_reason = out_reason_reg;

    // matcher update for one byte
    always_comb begin
        count_next      = count_reg;
        token_pos_next  = token_pos_reg;
        token_seen_next = token_seen_reg;
        term_pos_next   = term_pos_reg;
        head_end_next   = head_end_reg;
        bare_lf_next    = bare_lf_reg;
        prev_cr_next    = prev_cr_reg;
        method_next     = method_reg;
        ended_next      = ended_reg;

        take_byte = !ended_reg && (in_byte_reg != CHAR_NUL);
        if (!ended_reg && (in_byte_reg == CHAR_NUL)) begin
            ended_next = 1'b1;
        end

        if (take_byte) begin
            // drop method candidates that disagree at this position
            if (count_reg < 8'(METHOD_MAX)) begin
                for (int i = 0; i < METHOD_COUNT; i++) begin
                    if ((count_reg < {4'd0, METHOD_LEN[i]}) &&
                        (METHOD_TEXT[i][count_reg[2:0]] != in_byte_reg)) begin
                        method_next[i] = 1'b0;
                    end
                end
            end

            // LF without CR before the terminator
            if ((in_byte_reg == CHAR_LF) && !prev_cr_reg && !head_end_reg) begin
                bare_lf_next = 1'b1;
            end

            // token matcher
            if (!token_seen_reg) begin
                if (TOKEN_TEXT[token_pos_reg] == in_byte_reg) begin
                    if (token_pos_reg == 3'(TOKEN_LEN - 1)) begin
                        token_seen_next = 1'b1;
                        token_pos_next  = '0;
                    end else begin
                        token_pos_next = token_pos_reg + 3'd1;
                    end
                end else begin
                    token_pos_next = (in_byte_reg == CHAR_SPACE) ? 3'd1 : 3'd0;
                end
            end

            // terminator matcher
            if (!head_end_reg) begin
                if (TERM_TEXT[term_pos_reg] == in_byte_reg) begin
                    if (term_pos_reg == 2'(TERM_LEN - 1)) begin
                        head_end_next = 1'b1;
                        term_pos_next = '0;
                    end else begin
                        term_pos_next = term_pos_reg + 2'd1;
                    end
                end else begin
                    term_pos_next = (in_byte_reg == CHAR_CR) ? 2'd1 : 2'd0;
                end
            end

            prev_cr_next = (in_byte_reg == CHAR_CR);
            if (count_reg != COUNT_MAX) begin
                count_next = count_reg + 8'd1;
            end
        end
    end

    // verdict from the updated state
    always_comb begin
        method_ok = 1'b0;
        for (int i = 0; i < METHOD_COUNT; i++) begin
            if (method_next[i] && ({4'd0, METHOD_LEN[i]} <= count_next)) begin
                method_ok = 1'b1;
            end
        end

        priority if (count_next < min_len_reg) begin
            reason = REASON_SHORT;
        end else if (!token_seen_next) begin
            reason = REASON_NO_TOKEN;
        end else if (!head_end_next) begin
            reason = REASON_NO_TERM;
        end else if (bare_lf_next) begin
            reason = REASON_BARE_LF;
        end else if (!method_ok) begin
            reason = REASON_BAD_METHOD;
        end else begin
            reason = REASON_OK;
        end
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= MIN_LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            min_len_reg <= cfg_min_request_length;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_end_of_request;
        end
    end

    // matcher state; rearms after the final byte
    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && in_last_reg)) begin
            count_reg      <= '0;
            token_pos_reg  <= '0;
            token_seen_reg <= 1'b0;
            term_pos_reg   <= '0;
            head_end_reg   <= 1'b0;
            bare_lf_reg    <= 1'b0;
            prev_cr_reg    <= 1'b0;
            method_reg     <= '1;
            ended_reg      <= 1'b0;
        end else if (advance) begin
            count_reg      <= count_next;
            token_pos_reg  <= token_pos_next;
            token_seen_reg <= token_seen_next;
            term_pos_reg   <= term_pos_next;
            head_end_reg   <= head_end_next;
            bare_lf_reg    <= bare_lf_next;
            prev_cr_reg    <= prev_cr_next;
            method_reg     <= method_next;
            ended_reg      <= ended_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_accepted_reg <= (reason == REASON_OK);
            out_reason_reg   <= reason;
        end
    end

endmodule

// ===== bench/http_request_head_validator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HTTP request head validator testbench
// Streams request heads into the validator, one byte per item: first a short
// table of hand-written requests, then random requests, mostly well formed,
// under several minimum lengths and sender/receiver idle mixes. Every verdict is
// checked against its pinned table value or a byte-level predictor in the bench.
// ----------------------------------------------------------------------------
module http_request_head_validator_tb;
    import hrv_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake at all
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int SETTLE       = 4;     // pipeline depth plus margin
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_REQS   = 1;     // requests per other random phase
    localparam int BURST_REQS   = 2;     // requests in phases 3 and 4
    localparam int VERB_COUNT   = 7;

    localparam logic [63:0] HTTP_TOKEN = " HTTP/1.";
    localparam logic [31:0] HEAD_END   = 32'h0D0A_0D0A;

    typedef enum int {
        VERB_GET, VERB_POST, VERB_PUT, VERB_DELETE, VERB_HEAD, VERB_OPTIONS, VERB_PATCH
    } verb_t;

    // one row of the directed table: text, optional zero byte, optional pinned verdict
    typedef struct {
        string   text;
        int      nul_at;   // index of an inserted zero byte, -1 for none
        bit      pinned;
        reason_t want;
    } head_case_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_min_request_length;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_data_byte;
    logic       s_end_of_request;
    logic       m_valid;
    logic       m_ready;
    logic       m_accepted;
    logic [2:0] m_reject_reason;

    // predictor state
    byte_t      min_len_model;
    int         bytes_seen;
    int         tok_pos;
    bit         tok_found;
    int         crlf_pos;
    bit         head_done;
    bit         lone_lf;
    bit         last_cr;
    logic [6:0] verbs_alive;
    bit         nul_seen;

    reason_t    verdicts_due[$];
    head_case_t head_cases[$];
    int         fail_count   = 0;
    int         quiet_cycles = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    bit         hold_request   = 1'b0;

    http_request_head_validator uut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_min_request_length (cfg_min_request_length),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_data_byte            (s_data_byte),
        .s_end_of_request       (s_end_of_request),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_accepted             (m_accepted),
        .m_reject_reason        (m_reject_reason)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // method text, right aligned, and its length including the space
    function automatic logic [63:0] verb_text(input verb_t v);
        case (v)
            VERB_GET:     return "GET ";
            VERB_POST:    return "POST ";
            VERB_PUT:     return "PUT ";
            VERB_DELETE:  return "DELETE ";
            VERB_HEAD:    return "HEAD ";
            VERB_OPTIONS: return "OPTIONS ";
            default:      return "PATCH ";
        endcase
    endfunction

    function automatic int verb_len(input verb_t v);
        case (v)
            VERB_GET, VERB_PUT:   return 4;
            VERB_POST, VERB_HEAD: return 5;
            VERB_DELETE:          return 7;
            VERB_OPTIONS:         return 8;
            default:              return 6;
        endcase
    endfunction

    function automatic void clear_head_state();
        bytes_seen  = 0;
        tok_pos     = 0;
        tok_found   = 1'b0;
        crlf_pos    = 0;
        head_done   = 1'b0;
        lone_lf     = 1'b0;
        last_cr     = 1'b0;
        verbs_alive = '1;
        nul_seen    = 1'b0;
    endfunction

    // Fold one byte into the matchers; on the final byte return 1 with the verdict.
    function automatic bit judge_byte(input byte_t b, input bit last, output reason_t why);
        logic [63:0] vt;
        int          vl;
        bit          verb_ok;
        verb_ok = 1'b0;
        why     = REASON_OK;
        if (!nul_seen) begin
            if (b == CHAR_NUL) begin
                nul_seen = 1'b1;
            end else begin
                // drop methods that disagree at this position
                if (bytes_seen < 8) begin
                    for (int k = 0; k < VERB_COUNT; k++) begin
                        vt = verb_text(verb_t'(k));
                        vl = verb_len(verb_t'(k));
                        if (bytes_seen < vl && vt[8*(vl-1-bytes_seen) +: 8] != b)
                            verbs_alive[k] = 1'b0;
                    end
                end
                if (b == CHAR_LF && !last_cr && !head_done)
                    lone_lf = 1'b1;
                // " HTTP/1." search; a mismatched space restarts the match
                if (!tok_found) begin
                    if (HTTP_TOKEN[8*(7-tok_pos) +: 8] == b) begin
                        tok_pos++;
                        if (tok_pos == 8) begin
                            tok_found = 1'b1;
                            tok_pos   = 0;
                        end
                    end else begin
                        tok_pos = (b == CHAR_SPACE) ? 1 : 0;
                    end
                end
                // CR LF CR LF search
                if (!head_done) begin
                    if (HEAD_END[8*(3-crlf_pos) +: 8] == b) begin
                        crlf_pos++;
                        if (crlf_pos == 4) begin
                            head_done = 1'b1;
                            crlf_pos  = 0;
                        end
                    end else begin
                        crlf_pos = (b == CHAR_CR) ? 1 : 0;
                    end
                end
                last_cr = (b == CHAR_CR);
                if (bytes_seen < 255)
                    bytes_seen++;
            end
        end
        if (!last)
            return 1'b0;
        for (int k = 0; k < VERB_COUNT; k++) begin
            if (verbs_alive[k] && verb_len(verb_t'(k)) <= bytes_seen)
                verb_ok = 1'b1;
        end
        if (bytes_seen < min_len_model) why = REASON_SHORT;
        else if (!tok_found)            why = REASON_NO_TOKEN;
        else if (!head_done)            why = REASON_NO_TERM;
        else if (lone_lf)               why = REASON_BARE_LF;
        else if (!verb_ok)              why = REASON_BAD_METHOD;
        clear_head_state();
        return 1'b1;
    endfunction

    function automatic void add_text(ref byte_t q[$], input string s);
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
    endfunction

    // Random request: mostly a well-formed head with random content and the
    // odd flaw, otherwise raw noise.
    function automatic void compose_request(ref byte_t req[$], input bit pad_long);
        logic [63:0] vt;
        int          vl;
        int          n;
        verb_t       v;
        req.delete();
        if ($urandom_range(99) < 15) begin
            n = $urandom_range(1, 24);
            for (int i = 0; i < n; i++)
                req.push_back(byte_t'($urandom_range(255)));
            return;
        end
        if ($urandom_range(19) == 0)
            req.push_back(CHAR_LF);
        v  = verb_t'($urandom_range(VERB_COUNT - 1));
        vt = verb_text(v);
        vl = verb_len(v);
        for (int i = 0; i < vl; i++)
            req.push_back(vt[8*(vl-1-i) +: 8]);
        if ($urandom_range(9) == 0)
            req[$urandom_range(req.size() - 1)] = byte_t'($urandom_range(255));
        // path and version
        add_text(req, "/");
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
            req.push_back(byte_t'($urandom_range(33, 126)));
        add_text(req, " HTTP/1.");
        req.push_back(byte_t'($urandom_range(48, 57)));
        if ($urandom_range(9) == 0)
            req[req.size() - 1 - $urandom_range(8)] = byte_t'($urandom_range(255));
        // header lines, now and then with a bare LF
        n = $urandom_range(0, 3);
        for (int h = 0; h < n; h++) begin
            if ($urandom_range(19) == 0)
                add_text(req, "\n");
            else
                add_text(req, "\015\n");
            add_text(req, "X-");
            for (int i = $urandom_range(1, 8); i > 0; i--)
                req.push_back(byte_t'($urandom_range(32, 126)));
        end
        // a long header line to reach the byte count ceiling
        if (pad_long) begin
            add_text(req, "\015\nP: ");
            for (int i = $urandom_range(240, 260); i > 0; i--)
                req.push_back(byte_t'($urandom_range(32, 126)));
        end
        case ($urandom_range(9))
            0:       ;
            1:       add_text(req, "\015\n\n");
            default: add_text(req, "\015\n\015\n");
        endcase
        for (int i = $urandom_range(0, 3); i > 0; i--)
            req.push_back(byte_t'($urandom_range(255)));
        if ($urandom_range(19) == 0)
            req.insert($urandom_range(req.size()), CHAR_NUL);
    endfunction

    // Offer one item; called and returning at a falling edge.
    task automatic push_byte(input byte_t b, input bit last, input bit pinned,
                             input reason_t pinned_why);
        reason_t why;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_data_byte      <= b;
        s_end_of_request <= last;
        do @(posedge aclk); while (!s_ready);
        if (judge_byte(b, last, why))
            verdicts_due.push_back(pinned ? pinned_why : why);
        @(negedge aclk);
    endtask

    task automatic send_request(input byte_t req[$], input bit pinned, input reason_t want);
        for (int i = 0; i < req.size(); i++)
            push_byte(req[i], i == req.size() - 1, pinned, want);
    endtask

    // Quiet the sender and let every verdict come home.
    task automatic drain_verdicts();
        s_valid <= 1'b0;
        do @(negedge aclk); while (verdicts_due.size() != 0);
    endtask

    // Register write while idle.
    task automatic set_min_length(input byte_t v);
        drain_verdicts();
        repeat (SETTLE) @(negedge aclk);
        cfg_min_request_length <= v;
        cfg_valid              <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        min_len_model = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin : verdict_ready_drive
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_request <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Verdict check against the oldest expectation
    always @(posedge aclk) begin : verdict_check
        reason_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected verdict, expected none, actual accepted %0d reason %0d",
                         $time, m_accepted, m_reject_reason);
                fail_count++;
            end else begin
                want = verdicts_due.pop_front();
                if (m_accepted !== (want == REASON_OK)) begin
                    $display("%0t: m_accepted mismatch, expected %0d actual %0d",
                             $time, want == REASON_OK, m_accepted);
                    fail_count++;
                end
                if (m_reject_reason !== want) begin
                    $display("%0t: m_reject_reason mismatch, expected %0d actual %0d",
                             $time, want, m_reject_reason);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: any handshake counts as progress
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("http_request_head_validator_tb: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        byte_t req[$];
        int    phase_reqs;
        int    reqs_due;
        bit    pad_long;

        aresetn                = 1'b0;
        cfg_valid              = 1'b0;
        cfg_min_request_length = 8'd0;
        s_valid                = 1'b0;
        s_data_byte            = 8'd0;
        s_end_of_request       = 1'b0;
        min_len_model          = MIN_LEN_RESET;
        clear_head_state();

        // directed table, minimum length at its reset value of 10
        head_cases.push_back('{"GET / HTTP/1.1\015\n\015\n", -1, 1'b1, REASON_OK});
        head_cases.push_back('{"GET", -1, 1'b1, REASON_SHORT});
        head_cases.push_back('{"GET / HTTP/2.0\015\n\015\n", -1, 1'b1, REASON_NO_TOKEN});
        head_cases.push_back('{"GET / HTTP/1.1\015\nHost: a\015\n", -1, 1'b1, REASON_NO_TERM});
        head_cases.push_back('{"GET / HTTP/1.1\nHost: a\015\n\015\n", -1, 1'b1,
                               REASON_BARE_LF});
        // leading LF is bare, and it outranks the broken method
        head_cases.push_back('{"\nGET / HTTP/1.1\015\n\015\n", -1, 1'b1, REASON_BARE_LF});
        head_cases.push_back('{"FOO / HTTP/1.1\015\n\015\n", -1, 1'b1, REASON_BAD_METHOD});
        head_cases.push_back('{"POST / HTTP/1.1\015\n\015\n", -1, 1'b1, REASON_OK});
        head_cases.push_back('{"PUT / HTTP/1.1\015\n\015\n", -1, 1'b1, REASON_OK});
        head_cases.push_back('{"DELETE / HTTP/1.1\015\n\015\n", -1, 1'b1, REASON_OK});
        head_cases.push_back('{"HEAD / HTTP/1.1\015\n\015\n", -1, 1'b1, REASON_OK});
        head_cases.push_back('{"OPTIONS * HTTP/1.1\015\n\015\n", -1, 1'b1, REASON_OK});
        head_cases.push_back('{"PATCH / HTTP/1.1\015\n\015\n", -1, 1'b1, REASON_OK});
        // zero byte cuts the string: the rest is ignored
        head_cases.push_back('{"GET / HTTP/1.1\015\n\015\n", 5, 1'b1, REASON_SHORT});
        head_cases.push_back('{"GET / HTTP/1.1\015\n\015\n", 16, 1'b1, REASON_NO_TERM});
        head_cases.push_back('{"GET / HTTP/1.1\015\n\015\n", 18, 1'b1, REASON_OK});
        head_cases.push_back('{"", 0, 1'b1, REASON_SHORT});
        // the rest go through the predictor
        head_cases.push_back('{"GET /\377\001 HTTP/1.1\015\n\015\n", -1, 1'b0, REASON_OK});
        head_cases.push_back('{"GET /  HTTP/1.1\015\n\015\015\n\015\n", -1, 1'b0, REASON_OK});
        head_cases.push_back('{"GET / HTTP/1.1\015\n\n\015\n\015\n", -1, 1'b0, REASON_OK});
        head_cases.push_back('{"get / HTTP/1.1\015\n\015\n", -1, 1'b0, REASON_OK});
        head_cases.push_back('{"GETX HTTP/1.1\015\n\015\n", -1, 1'b0, REASON_OK});
        head_cases.push_back('{"HEAD HTTP/1.1\015\n\015\n\n\377", -1, 1'b0, REASON_OK});
        head_cases.push_back('{"POST /\015\n\015\n HTTP/1.", -1, 1'b0, REASON_OK});

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (head_cases[r]) begin
            req.delete();
            for (int i = 0; i <= head_cases[r].text.len(); i++) begin
                if (i == head_cases[r].nul_at)
                    req.push_back(CHAR_NUL);
                if (i < head_cases[r].text.len())
                    req.push_back(head_cases[r].text[i]);
            end
            send_request(req, head_cases[r].pinned, head_cases[r].want);
        end

        // random phases: minimum length and idle mix per phase
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin set_min_length(8'd0);   send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin set_min_length(8'd255); send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin
                    set_min_length(byte_t'($urandom_range(255)));
                    send_idle_pct = 0;  recv_stall_pct = 83;
                end
                3: begin
                    set_min_length(byte_t'($urandom_range(8, 24)));
                    send_idle_pct = 26; recv_stall_pct = 26;
                end
                4: begin
                    set_min_length(MIN_LEN_RESET);
                    send_idle_pct = 0;  recv_stall_pct = 0;
                    hold_request <= 1'b1;
                end
                default: begin
                    set_min_length(byte_t'($urandom_range(255)));
                    send_idle_pct = 26; recv_stall_pct = 26;
                end
            endcase
            phase_reqs = 0;
            reqs_due   = (phase == 3 || phase == 4) ? BURST_REQS : PHASE_REQS;
            while (phase_reqs < reqs_due) begin
                // one request past the byte count ceiling while the minimum is 255
                pad_long = (phase == 1 && phase_reqs == 0);
                compose_request(req, pad_long);
                send_request(req, 1'b0, REASON_OK);
                phase_reqs++;
                // sender pause until every verdict is back
                if (phase == 3 && phase_reqs == 1)
                    drain_verdicts();
            end
        end

        drain_verdicts();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("http_request_head_validator_tb: PASS");
        else
            $display("http_request_head_validator_tb: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/hrv_pkg.sv
rtl/http_request_head_validator.sv
bench/http_request_head_validator_tb.sv
